// ===== hw/rtl/ckvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckvt_pkg
// Shared types and constants of the compact key/value table.
// ----------------------------------------------------------------------------
package ckvt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int HALF_W          = 32;
	localparam int KEY_W           = 2 * HALF_W;
	localparam int VAL_W           = 2 * HALF_W;
	localparam int CMD_W           = 2;
	localparam int COUNT_OUT_W     = 5;
	localparam int CAP_W           = 5;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [HALF_W-1:0] key_a;
		logic [HALF_W-1:0] key_b;
		logic [HALF_W-1:0] value_c;
		logic [HALF_W-1:0] value_d;
	} req_item_t;

	typedef struct packed {
		logic                   success;
		logic [HALF_W-1:0]      found_c;
		logic [HALF_W-1:0]      found_d;
		logic [COUNT_OUT_W-1:0] entry_count;
	} rsp_item_t;

	typedef struct packed {
		logic             match_en;
		logic             update;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

	typedef struct packed {
		logic             hit_seen;
		logic             free_seen;
		logic [VAL_W-1:0] found;
	} chain_up_t;

	typedef struct packed {
		logic             valid_above;
		logic [KEY_W-1:0] move_key;
		logic [VAL_W-1:0] move_value;
	} chain_dn_t;

endpackage

// ===== hw/rtl/ckvt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckvt_cell
// One table slot: key, value and valid mark, with its links to both neighbors.
// ----------------------------------------------------------------------------
module ckvt_cell
	import ckvt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      in_use,
	input  logic      any_hit,
	input  chain_up_t up_in,
	output chain_up_t up_out,
	input  chain_dn_t dn_in,
	output chain_dn_t dn_out
);

	logic             valid_q;
	logic             match_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic hit;
	logic first_hit;
	logic first_free;
	logic occupied;
	logic last_valid;

	assign hit        = valid_q & in_use & match_q;
	assign first_hit  = hit & ~up_in.hit_seen;
	assign first_free = ~valid_q & in_use & ~up_in.free_seen;
	assign occupied   = valid_q & in_use;

	assign up_out.hit_seen  = up_in.hit_seen | hit;
	assign up_out.free_seen = up_in.free_seen | (~valid_q & in_use);
	assign up_out.found     = first_hit ? value_q : up_in.found;

	assign last_valid = occupied & ~dn_in.valid_above & up_out.hit_seen;

	assign dn_out.valid_above = dn_in.valid_above | occupied;
	assign dn_out.move_key    = last_valid ? key_q : dn_in.move_key;
	assign dn_out.move_value  = last_valid ? value_q : dn_in.move_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.update) begin
			case (ctl.cmd)
				CMD_ADD: begin
					if (!any_hit && first_free)
						valid_q <= 1'b1;
				end
				CMD_REMOVE: begin
					if (last_valid)
						valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.match_en)
			match_q <= (key_q == ctl.key);
		if (ctl.update) begin
			case (ctl.cmd)
				CMD_ADD: begin
					if (any_hit && first_hit) begin
						value_q <= ctl.value;
					end else if (!any_hit && first_free) begin
						key_q   <= ctl.key;
						value_q <= ctl.value;
					end
				end
				CMD_REMOVE: begin
					if (first_hit) begin
						key_q   <= dn_out.move_key;
						value_q <= dn_out.move_value;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/compact_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_key_value_table
// Associative table of key/value entries kept packed at the low slots.
// Each request takes a match state, then an update state on the row of slot
// cells, where its result is registered; a held result stalls only the update
// state. A new request can be accepted in the update state that ends the last one.
// Reset clears all valid marks and the entry count and sets the capacity in
// use to 16; keys and values are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
module compact_key_value_table
	import ckvt_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_item_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_item_t         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_MATCH  = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	localparam logic           REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;

	logic [1:0]       state_q;
	req_item_t        req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;
	logic [CAP_W-1:0] capacity_q;
	rsp_item_t        rsp_q;
	logic             rsp_valid_q;

	logic      accept;
	logic      fire_upd;
	logic      any_hit;
	logic      any_free;
	logic      success;
	logic      cfg_wr;
	cell_ctl_t ctl;

	logic [TABLE_DEPTH-1:0] in_use;
	chain_up_t              up_c [0:TABLE_DEPTH];
	chain_dn_t              dn_c [0:TABLE_DEPTH];

	assign fire_upd  = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_ready);
	assign req_ready = (state_q == ST_IDLE) || fire_upd;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= ST_MATCH;
		end else begin
			unique case (state_q)
				ST_IDLE:   state_q <= ST_IDLE;
				ST_MATCH:  state_q <= ST_UPDATE;
				ST_UPDATE: if (fire_upd) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req;
	end

	assign ctl.match_en = (state_q == ST_MATCH);
	assign ctl.update   = fire_upd;
	assign ctl.cmd      = req_q.command;
	assign ctl.key      = {req_q.key_a, req_q.key_b};
	assign ctl.value    = {req_q.value_c, req_q.value_d};

	assign up_c[0]           = '0;
	assign dn_c[TABLE_DEPTH] = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		assign in_use[g] = (32'(g) < 32'(capacity_q));

		ckvt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.in_use  (in_use[g]),
			.any_hit (any_hit),
			.up_in   (up_c[g]),
			.up_out  (up_c[g+1]),
			.dn_in   (dn_c[g+1]),
			.dn_out  (dn_c[g])
		);
	end

	assign any_hit  = up_c[TABLE_DEPTH].hit_seen;
	assign any_free = up_c[TABLE_DEPTH].free_seen;

	always_comb begin
		success = 1'b0;
		count_n = count_q;
		case (req_q.command)
			CMD_GET: success = any_hit;
			CMD_ADD: begin
				success = any_hit || any_free;
				if (!any_hit && any_free)
					count_n = count_q + 1'b1;
			end
			CMD_REMOVE: begin
				success = any_hit;
				if (any_hit && count_q != '0)
					count_n = count_q - 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire_upd) begin
				count_q     <= count_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_upd) begin
			rsp_q.success     <= success;
			rsp_q.entry_count <= COUNT_OUT_W'(count_n);
			if (any_hit && (req_q.command == CMD_GET || req_q.command == CMD_REMOVE)) begin
				rsp_q.found_c <= up_c[TABLE_DEPTH].found[VAL_W-1:HALF_W];
				rsp_q.found_d <= up_c[TABLE_DEPTH].found[HALF_W-1:0];
			end else begin
				rsp_q.found_c <= '0;
				rsp_q.found_d <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_q) : '0;

endmodule

// ===== tb/compact_key_value_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compact_key_value_table_tb
// Self-checking bench for the compact key/value table. A directed sequence
// covers hits, misses, updates, compaction on remove, a full table, the unused
// command and capacity settings of zero, one, a lowered value and a saturating
// value. Random blocks follow, drawing keys mostly from a small pool so that
// hits, updates and full conditions stay frequent. Each accepted request is
// applied to a local copy of the table, and every response is compared with
// the oldest predicted one. Sender and receiver idle at random.
// ----------------------------------------------------------------------------
module compact_key_value_table_tb;
	import ckvt_pkg::*;

	localparam int DEPTH       = TABLE_DEPTH_DEF;
	localparam int POOL_N      = 20;
	localparam int BLOCK_ITEMS = 100;
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [ADDR_W-1:0] CAP_ADDR   = 3'd0;
	localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_item_t         req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_item_t         rsp;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	req_item_t req_backlog[$];
	rsp_item_t rsp_due[$];
	rsp_item_t rsp_exp;

	logic             slot_used [DEPTH];
	logic [KEY_W-1:0] slot_key  [DEPTH];
	logic [VAL_W-1:0] slot_val  [DEPTH];
	int               used_count;
	logic [CAP_W-1:0] cap_reg;
	logic [KEY_W-1:0] key_pool  [POOL_N];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          fail_count    = 0;
	logic [31:0] cycle_cnt     = '0;

	compact_key_value_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #10 clk = ~clk;

	function automatic rsp_item_t table_op_result(req_item_t r);
		rsp_item_t        res;
		logic [KEY_W-1:0] k;
		int               n_use;
		int               hit;
		int               last;
		int               i;
		res   = '0;
		k     = {r.key_a, r.key_b};
		n_use = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		hit   = -1;
		for (i = 0; i < n_use; i++)
			if (hit < 0 && slot_used[i] && slot_key[i] == k)
				hit = i;
		case (r.command)
			CMD_GET: begin
				if (hit >= 0) begin
					res.success = 1'b1;
					{res.found_c, res.found_d} = slot_val[hit];
				end
			end
			CMD_ADD: begin
				if (hit >= 0) begin
					slot_val[hit] = {r.value_c, r.value_d};
					res.success = 1'b1;
				end else begin
					for (i = 0; i < n_use; i++) begin
						if (!res.success && !slot_used[i]) begin
							slot_used[i] = 1'b1;
							slot_key[i]  = k;
							slot_val[i]  = {r.value_c, r.value_d};
							used_count++;
							res.success = 1'b1;
						end
					end
				end
			end
			CMD_REMOVE: begin
				if (hit >= 0) begin
					res.success = 1'b1;
					{res.found_c, res.found_d} = slot_val[hit];
					last = hit;
					for (i = hit + 1; i < n_use; i++)
						if (slot_used[i])
							last = i;
					slot_key[hit]   = slot_key[last];
					slot_val[hit]   = slot_val[last];
					slot_used[last] = 1'b0;
					if (used_count > 0)
						used_count--;
				end
			end
			default: ;
		endcase
		res.entry_count = used_count[COUNT_OUT_W-1:0];
		return res;
	endfunction

	function automatic req_item_t mk_req(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
			logic [VAL_W-1:0] v);
		req_item_t r;
		r.command = cmd;
		{r.key_a, r.key_b} = k;
		{r.value_c, r.value_d} = v;
		return r;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && req_ready)
				rsp_due.push_back(table_op_result(req));
			if (!req_valid || req_ready) begin
				if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req       <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected response: success=%0d c=%h d=%h count=%0d",
							rsp.success, rsp.found_c, rsp.found_d, rsp.entry_count);
				end else begin
					rsp_exp = rsp_due.pop_front();
					if (rsp.success !== rsp_exp.success || rsp.found_c !== rsp_exp.found_c ||
							rsp.found_d !== rsp_exp.found_d ||
							rsp.entry_count !== rsp_exp.entry_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"response mismatch: expected success=%0d c=%h d=%h ",
								"count=%0d, got success=%0d c=%h d=%h count=%0d"},
								rsp_exp.success, rsp_exp.found_c, rsp_exp.found_d,
								rsp_exp.entry_count, rsp.success, rsp.found_c,
								rsp.found_d, rsp.entry_count);
					end
				end
			end
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_idle();
		while (req_backlog.size() > 0 || req_valid || rsp_due.size() > 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == CAP_ADDR)
			cap_reg = data[CAP_W-1:0];
		@(negedge clk);
	endtask

	task automatic set_capacity(int cap);
		logic [DATA_W-1:0] junk;
		junk = $urandom;
		wait_idle();
		write_reg(CAP_ADDR, {junk[DATA_W-1:CAP_W], cap[CAP_W-1:0]});
	endtask

	// drop some of the current entries so the table does not clog with stale keys
	task automatic queue_clears();
		int i;
		for (i = 0; i < DEPTH; i++)
			if (slot_used[i] && $urandom_range(1) == 1)
				req_backlog.push_back(mk_req(CMD_REMOVE, slot_key[i], {$urandom, $urandom}));
	endtask

	task automatic queue_random_block(int n);
		int               j;
		int               pick;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] k;
		for (j = 0; j < n; j++) begin
			pick = $urandom_range(99);
			if (pick < 30)
				cmd = CMD_GET;
			else if (pick < 70)
				cmd = CMD_ADD;
			else if (pick < 95)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(9) == 0)
				k = {$urandom, $urandom};
			else
				k = key_pool[$urandom_range(POOL_N - 1)];
			req_backlog.push_back(mk_req(cmd, k, {$urandom, $urandom}));
		end
	endtask

	initial begin
		int i;
		int ph;
		int b;
		int cap;
		logic [KEY_W-1:0] k0, k1, k2, k3, ka, kb, kc;

		for (i = 0; i < DEPTH; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i]  = '0;
			slot_val[i]  = '0;
		end
		used_count = 0;
		cap_reg    = 5'd16;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (i = 2; i < POOL_N; i++)
			key_pool[i] = {$urandom, $urandom};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 52;

		k0 = '0;
		k1 = '1;
		k2 = {32'hffff_ffff, 32'h0000_0000};
		k3 = {32'h0000_0000, 32'hffff_ffff};
		req_backlog.push_back(mk_req(CMD_GET,    k0, '1));
		req_backlog.push_back(mk_req(CMD_REMOVE, k0, '1));
		req_backlog.push_back(mk_req(CMD_ADD,    k0, {32'hffff_ffff, 32'h0}));
		req_backlog.push_back(mk_req(CMD_ADD,    k1, {32'h0, 32'hffff_ffff}));
		req_backlog.push_back(mk_req(CMD_ADD,    k2, {32'ha5a5_a5a5, 32'h5a5a_5a5a}));
		req_backlog.push_back(mk_req(CMD_ADD,    k0, {32'h1234_5678, 32'h9abc_def0}));
		req_backlog.push_back(mk_req(CMD_GET,    k0, '0));
		req_backlog.push_back(mk_req(CMD_GET,    k1, '0));
		req_backlog.push_back(mk_req(CMD_GET,    k3, '0));
		req_backlog.push_back(mk_req(CMD_UNUSED, k1, '1));
		req_backlog.push_back(mk_req(CMD_REMOVE, k0, '0));
		req_backlog.push_back(mk_req(CMD_GET,    k2, '0));
		req_backlog.push_back(mk_req(CMD_REMOVE, k2, '0));
		req_backlog.push_back(mk_req(CMD_REMOVE, k1, '0));

		// two usable slots: fill, overflow, update, compact
		ka = {$urandom, $urandom};
		kb = {$urandom, $urandom};
		kc = {$urandom, $urandom};
		set_capacity(2);
		req_backlog.push_back(mk_req(CMD_ADD,    ka, {$urandom, $urandom}));
		req_backlog.push_back(mk_req(CMD_ADD,    kb, {$urandom, $urandom}));
		req_backlog.push_back(mk_req(CMD_ADD,    kc, {$urandom, $urandom}));
		req_backlog.push_back(mk_req(CMD_ADD,    ka, {$urandom, $urandom}));
		req_backlog.push_back(mk_req(CMD_REMOVE, ka, '0));
		req_backlog.push_back(mk_req(CMD_ADD,    kc, {$urandom, $urandom}));

		// lowered capacity hides slot one; zero capacity hides all
		set_capacity(1);
		req_backlog.push_back(mk_req(CMD_GET, kc, '0));
		req_backlog.push_back(mk_req(CMD_ADD, ka, {$urandom, $urandom}));
		set_capacity(0);
		req_backlog.push_back(mk_req(CMD_GET, kb, '0));
		req_backlog.push_back(mk_req(CMD_ADD, ka, {$urandom, $urandom}));
		wait_idle();
		write_reg(SPARE_ADDR, '1);
		set_capacity(31);
		req_backlog.push_back(mk_req(CMD_GET, kc, '0));

		for (ph = 0; ph < 3; ph++) begin
			wait_idle();
			send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 52 : 0;
			recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 9 : 0;
			for (b = 0; b < 5; b++) begin
				case ($urandom_range(9))
					0:       cap = 0;
					1:       cap = 1;
					2, 3:    cap = 16;
					4:       cap = $urandom_range(17, 31);
					default: cap = $urandom_range(2, 15);
				endcase
				set_capacity(cap);
				if ($urandom_range(9) == 0)
					write_reg(SPARE_ADDR, $urandom);
				queue_clears();
				queue_random_block(BLOCK_ITEMS);
			end
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && rsp_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
